/* sv/tvsd_pkg.sv */
// Shared constants and types for the tagged value stream decoder.
// Used by tagged_value_stream_decoder; depends on nothing.
package tvsd_pkg;

    // Widest payload length accepted; longer declared lengths are rejected.
    localparam int unsigned LENGTH_WIDTH = 32;
    localparam logic [31:0] LEN_MAX = 32'((64'(1) << LENGTH_WIDTH) - 64'(1));

    // Tag bytes
    localparam logic [7:0] TAG_U8   = 8'h80;
    localparam logic [7:0] TAG_U16  = 8'h81;
    localparam logic [7:0] TAG_U32  = 8'h82;
    localparam logic [7:0] TAG_U64  = 8'h83;
    localparam logic [7:0] TAG_BARR = 8'h85;
    localparam logic [7:0] TAG_STR  = 8'h86;

    // Element kind held while an element is decoded (0..3 are number size codes)
    localparam logic [2:0] ELEM_STR  = 3'd4;
    localparam logic [2:0] ELEM_BARR = 3'd5;

    // Bytes of the big-endian length field
    localparam logic [3:0] LEN_BYTES = 4'd4;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_NUMBER  = 3'd0,
        KIND_STR_HDR = 3'd1,
        KIND_ARR_HDR = 3'd2,
        KIND_PAYLOAD = 3'd3,
        KIND_END     = 3'd4,
        KIND_TRUNC   = 3'd5
    } t_kind;

endpackage

/* sv/tagged_value_stream_decoder.sv */
// Tagged value stream decoder: one byte in, at most one result out per request.
// Results are registered; one byte per cycle unless the result output stalls.
// A single decode step sits between the parser state registers and the result register.
// Reset (i_rst_n low, synchronous) returns the parser to expect-tag and empties the output.
// Depends on tvsd_pkg.
module tagged_value_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_buffer,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_out_kind,
    output logic [63:0] o_number_value,
    output logic [1:0]  o_number_width,
    output logic [31:0] o_payload_length,
    output logic [7:0]  o_payload_byte,
    output logic        o_item_done,
    output logic        o_last_of_buffer
);

    // Parser phase
    typedef enum logic [2:0] {
        PH_TAG     = 3'd0,
        PH_NUM     = 3'd1,
        PH_LEN     = 3'd2,
        PH_PAY     = 3'd3,
        PH_DISCARD = 3'd4
    } t_phase;

    // Parser state
    t_phase                                r_phase, n_phase;
    logic [2:0]                            r_tag, n_tag;
    logic [3:0]                            r_cnt, n_cnt;
    logic [63:0]                           r_acc, n_acc;
    logic [tvsd_pkg::LENGTH_WIDTH-1:0]     r_rem, n_rem;

    // Result register
    logic        r_out_valid;
    logic [2:0]  r_kind;
    logic [63:0] r_num;
    logic [1:0]  r_width;
    logic [31:0] r_len;
    logic [7:0]  r_pbyte;
    logic        r_done;
    logic        r_last;

    // Decode step outputs
    logic        emit;
    logic [2:0]  res_kind;
    logic [63:0] res_num;
    logic [1:0]  res_width;
    logic [31:0] res_len;
    logic [7:0]  res_pbyte;
    logic        res_done;
    logic        res_last;

    logic [63:0] acc_sh;
    logic [3:0]  cnt_dec;
    logic [31:0] len;
    logic [tvsd_pkg::LENGTH_WIDTH-1:0] rem_dec;
    logic        accept;

    // The output register frees up when it is empty or being drained this cycle,
    // so a new byte is taken in the same cycle a waiting result leaves.
    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    assign acc_sh  = {r_acc[55:0], i_in_byte};
    assign cnt_dec = r_cnt - 4'd1;
    assign len     = acc_sh[31:0];
    assign rem_dec = r_rem - tvsd_pkg::LENGTH_WIDTH'(1);

    always_comb begin
        n_phase   = r_phase;
        n_tag     = r_tag;
        n_cnt     = r_cnt;
        n_acc     = r_acc;
        n_rem     = r_rem;
        emit      = 1'b0;
        res_kind  = tvsd_pkg::KIND_NUMBER;
        res_num   = '0;
        res_width = '0;
        res_len   = '0;
        res_pbyte = '0;
        res_done  = 1'b0;
        res_last  = 1'b0;

        case (r_phase)
            PH_NUM: begin
                n_acc = acc_sh;
                n_cnt = cnt_dec;
                if (cnt_dec == 4'd0) begin
                    res_kind  = tvsd_pkg::KIND_NUMBER;
                    res_num   = acc_sh;
                    res_width = r_tag[1:0];
                    res_done  = 1'b1;
                    n_phase   = PH_TAG;
                    emit      = 1'b1;
                end else if (i_end_of_buffer) begin
                    res_kind = tvsd_pkg::KIND_TRUNC;
                    emit     = 1'b1;
                end
            end
            PH_LEN: begin
                n_acc = acc_sh;
                n_cnt = cnt_dec;
                if (cnt_dec == 4'd0) begin
                    if (len > tvsd_pkg::LEN_MAX) begin
                        // oversized length: drop the rest of the buffer
                        n_phase = PH_DISCARD;
                        if (i_end_of_buffer) begin
                            res_kind = tvsd_pkg::KIND_TRUNC;
                            emit     = 1'b1;
                        end
                    end else if (i_end_of_buffer && len != 32'd0) begin
                        res_kind = tvsd_pkg::KIND_TRUNC;
                        emit     = 1'b1;
                    end else begin
                        res_kind = (r_tag == tvsd_pkg::ELEM_STR) ? tvsd_pkg::KIND_STR_HDR
                                                                 : tvsd_pkg::KIND_ARR_HDR;
                        res_len  = len;
                        res_done = (len == 32'd0);
                        n_rem    = len[tvsd_pkg::LENGTH_WIDTH-1:0];
                        n_phase  = (len != 32'd0) ? PH_PAY : PH_TAG;
                        emit     = 1'b1;
                    end
                end else if (i_end_of_buffer) begin
                    res_kind = tvsd_pkg::KIND_TRUNC;
                    emit     = 1'b1;
                end
            end
            PH_PAY: begin
                n_rem = rem_dec;
                emit  = 1'b1;
                if (rem_dec == '0) begin
                    res_kind  = tvsd_pkg::KIND_PAYLOAD;
                    res_pbyte = i_in_byte;
                    res_done  = 1'b1;
                    n_phase   = PH_TAG;
                end else if (i_end_of_buffer) begin
                    res_kind = tvsd_pkg::KIND_TRUNC;
                end else begin
                    res_kind  = tvsd_pkg::KIND_PAYLOAD;
                    res_pbyte = i_in_byte;
                end
            end
            PH_DISCARD: begin
                if (i_end_of_buffer) begin
                    res_kind = tvsd_pkg::KIND_TRUNC;
                    emit     = 1'b1;
                end
            end
            default: begin
                // expect tag; zero and unknown bytes are skipped
                if (i_in_byte inside {[tvsd_pkg::TAG_U8:tvsd_pkg::TAG_U64]}) begin
                    n_tag   = {1'b0, i_in_byte[1:0]};
                    n_cnt   = 4'd1 << i_in_byte[1:0];
                    n_acc   = '0;
                    n_phase = PH_NUM;
                end else if (i_in_byte inside {tvsd_pkg::TAG_STR, tvsd_pkg::TAG_BARR}) begin
                    n_tag   = (i_in_byte == tvsd_pkg::TAG_STR) ? tvsd_pkg::ELEM_STR
                                                               : tvsd_pkg::ELEM_BARR;
                    n_cnt   = tvsd_pkg::LEN_BYTES;
                    n_acc   = '0;
                    n_phase = PH_LEN;
                end else begin
                    n_phase = PH_TAG;
                end
                if (i_end_of_buffer) begin
                    res_kind = (n_phase != PH_TAG) ? tvsd_pkg::KIND_TRUNC
                                                   : tvsd_pkg::KIND_END;
                    emit     = 1'b1;
                end
            end
        endcase

        // Final byte: always one result, and the parser starts over clean.
        if (i_end_of_buffer) begin
            res_last = 1'b1;
            if (!emit) begin
                res_kind = tvsd_pkg::KIND_TRUNC;
                emit     = 1'b1;
            end
            n_phase = PH_TAG;
            n_tag   = '0;
            n_cnt   = '0;
            n_acc   = '0;
            n_rem   = '0;
        end
    end

    // Parser state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_TAG;
            r_tag       <= '0;
            r_cnt       <= '0;
            r_acc       <= '0;
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase     <= n_phase;
                r_tag       <= n_tag;
                r_cnt       <= n_cnt;
                r_acc       <= n_acc;
                r_rem       <= n_rem;
                r_out_valid <= emit;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= res_kind;
            r_num   <= res_num;
            r_width <= res_width;
            r_len   <= res_len;
            r_pbyte <= res_pbyte;
            r_done  <= res_done;
            r_last  <= res_last;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_out_kind       = r_kind;
    assign o_number_value   = r_num;
    assign o_number_width   = r_width;
    assign o_payload_length = r_len;
    assign o_payload_byte   = r_pbyte;
    assign o_item_done      = r_done;
    assign o_last_of_buffer = r_last;

endmodule

/* tb/tb_tagged_value_stream_decoder.sv */
// Self-checking testbench for tagged_value_stream_decoder: byte requests in, decoded tokens out.
// A built-in decoder model predicts every token; a clocked monitor compares them field by field.
// Depends on tvsd_pkg and the decoder RTL only.
`timescale 1ns / 1ps

module tb_tagged_value_stream_decoder;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RAND_BYTES    = 290;   // per idling phase, four phases
    localparam logic [63:0] LEN_LIMIT = (64'd1 << tvsd_pkg::LENGTH_WIDTH) - 64'd1;

    // decoder model phases
    typedef enum logic [2:0] {
        PH_TAG  = 3'd0,
        PH_NUM  = 3'd1,
        PH_LEN  = 3'd2,
        PH_PAY  = 3'd3,
        PH_SKIP = 3'd4
    } t_phase;

    typedef struct {
        logic [7:0] data;
        logic       eob;
    } t_byte_req;

    typedef struct {
        tvsd_pkg::t_kind kind;
        logic [63:0]     value;
        logic [1:0]      width;
        logic [31:0]     len;
        logic [7:0]      pbyte;
        logic            done;
        logic            last;
    } t_token;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_in_byte = 8'h00;
    logic        i_end_of_buffer = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_out_kind;
    logic [63:0] o_number_value;
    logic [1:0]  o_number_width;
    logic [31:0] o_payload_length;
    logic [7:0]  o_payload_byte;
    logic        o_item_done;
    logic        o_last_of_buffer;

    tagged_value_stream_decoder u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_in_byte        (i_in_byte),
        .i_end_of_buffer  (i_end_of_buffer),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_out_kind       (o_out_kind),
        .o_number_value   (o_number_value),
        .o_number_width   (o_number_width),
        .o_payload_length (o_payload_length),
        .o_payload_byte   (o_payload_byte),
        .o_item_done      (o_item_done),
        .o_last_of_buffer (o_last_of_buffer)
    );

    int cycles = 0;
    int fail_count = 0;
    int token_count = 0;
    int queued_bytes = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    t_byte_req  byte_reqs[$];        // requests not yet presented
    t_token     expected_tokens[$];  // predicted tokens not yet seen
    logic [7:0] frame[$];            // buffer under construction

    // decoder model state
    t_phase      dec_phase = PH_TAG;
    logic [2:0]  dec_tag = 3'd0;
    logic [3:0]  dec_cnt = 4'd0;
    logic [63:0] dec_acc = 64'd0;
    logic [31:0] dec_rem = 32'd0;

    initial begin
        forever begin
            #5 i_clk = 1'b1;
            cycles++;
            #5 i_clk = 1'b0;
        end
    end

    function automatic void clear_decoder();
        dec_phase = PH_TAG;
        dec_tag   = 3'd0;
        dec_cnt   = 4'd0;
        dec_acc   = 64'd0;
        dec_rem   = 32'd0;
    endfunction

    // Model of one accepted byte; queues the token it causes, if any.
    function automatic void decode_byte(input logic [7:0] b, input logic eob);
        t_token      tok;
        logic        emit;
        logic [31:0] len;
        tok  = '{tvsd_pkg::KIND_NUMBER, 64'd0, 2'd0, 32'd0, 8'd0, 1'b0, 1'b0};
        emit = 1'b0;
        case (dec_phase)
            PH_NUM: begin
                dec_acc = {dec_acc[55:0], b};
                dec_cnt = dec_cnt - 4'd1;
                if (dec_cnt == 4'd0) begin
                    tok.kind  = tvsd_pkg::KIND_NUMBER;
                    tok.value = dec_acc;
                    tok.width = dec_tag[1:0];
                    tok.done  = 1'b1;
                    dec_phase = PH_TAG;
                    emit      = 1'b1;
                end else if (eob) begin
                    tok.kind = tvsd_pkg::KIND_TRUNC;
                    emit     = 1'b1;
                end
            end
            PH_LEN: begin
                dec_acc = {dec_acc[55:0], b};
                dec_cnt = dec_cnt - 4'd1;
                if (dec_cnt == 4'd0) begin
                    len = dec_acc[31:0];
                    if (64'(len) > LEN_LIMIT) begin
                        // oversize length: drop the rest of the buffer, truncation on its last byte
                        dec_phase = PH_SKIP;
                        if (eob) begin
                            tok.kind = tvsd_pkg::KIND_TRUNC;
                            emit     = 1'b1;
                        end
                    end else if (eob && len != 32'd0) begin
                        tok.kind = tvsd_pkg::KIND_TRUNC;
                        emit     = 1'b1;
                    end else begin
                        tok.kind  = (dec_tag == tvsd_pkg::ELEM_STR) ? tvsd_pkg::KIND_STR_HDR
                                                                    : tvsd_pkg::KIND_ARR_HDR;
                        tok.len   = len;
                        tok.done  = (len == 32'd0);
                        dec_rem   = len;
                        dec_phase = (len != 32'd0) ? PH_PAY : PH_TAG;
                        emit      = 1'b1;
                    end
                end else if (eob) begin
                    tok.kind = tvsd_pkg::KIND_TRUNC;
                    emit     = 1'b1;
                end
            end
            PH_PAY: begin
                dec_rem = dec_rem - 32'd1;
                if (dec_rem == 32'd0) begin
                    tok.kind  = tvsd_pkg::KIND_PAYLOAD;
                    tok.pbyte = b;
                    tok.done  = 1'b1;
                    dec_phase = PH_TAG;
                end else if (eob) begin
                    tok.kind = tvsd_pkg::KIND_TRUNC;
                end else begin
                    tok.kind  = tvsd_pkg::KIND_PAYLOAD;
                    tok.pbyte = b;
                end
                emit = 1'b1;
            end
            PH_SKIP: begin
                if (eob) begin
                    tok.kind = tvsd_pkg::KIND_TRUNC;
                    emit     = 1'b1;
                end
            end
            default: begin
                if (b >= tvsd_pkg::TAG_U8 && b <= tvsd_pkg::TAG_U64) begin
                    dec_tag   = 3'(b - tvsd_pkg::TAG_U8);
                    dec_cnt   = 4'd1 << dec_tag;
                    dec_acc   = 64'd0;
                    dec_phase = PH_NUM;
                end else if (b == tvsd_pkg::TAG_STR || b == tvsd_pkg::TAG_BARR) begin
                    dec_tag   = (b == tvsd_pkg::TAG_STR) ? tvsd_pkg::ELEM_STR
                                                         : tvsd_pkg::ELEM_BARR;
                    dec_cnt   = tvsd_pkg::LEN_BYTES;
                    dec_acc   = 64'd0;
                    dec_phase = PH_LEN;
                end else begin
                    // zero byte or unknown tag: skipped
                    dec_phase = PH_TAG;
                end
                if (eob) begin
                    tok.kind = (dec_phase != PH_TAG) ? tvsd_pkg::KIND_TRUNC
                                                     : tvsd_pkg::KIND_END;
                    emit     = 1'b1;
                end
            end
        endcase
        if (eob) begin
            tok.last = 1'b1;
            if (!emit) begin
                tok.kind = tvsd_pkg::KIND_TRUNC;
                emit     = 1'b1;
            end
            clear_decoder();
        end
        if (emit)
            expected_tokens.insert(expected_tokens.size(), tok);
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        fail_count++;
        $display("MISMATCH token %0d %s: got 0x%0h, expected 0x%0h",
                 token_count, what, got, want);
    endtask

    // Request driver: presents the next byte once the previous one is taken.
    always @(posedge i_clk) begin : drive_reqs
        t_byte_req nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            clear_decoder();
        end else begin
            if (i_valid && o_ready)
                decode_byte(i_in_byte, i_end_of_buffer);
            if (!i_valid || o_ready) begin
                if (byte_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = byte_reqs.pop_front();
                    i_valid         <= 1'b1;
                    i_in_byte       <= nxt.data;
                    i_end_of_buffer <= nxt.eob;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Token monitor: random backpressure, checks each accepted token.
    always @(posedge i_clk) begin : watch_tokens
        t_token want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
            if (o_valid && i_ready) begin
                if (expected_tokens.size() == 0) begin
                    flag_mismatch("unexpected token, kind", 64'(o_out_kind), 64'd0);
                end else begin
                    want = expected_tokens.pop_front();
                    if (o_out_kind !== want.kind)
                        flag_mismatch("kind", 64'(o_out_kind), 64'(want.kind));
                    if (o_number_value !== want.value)
                        flag_mismatch("number_value", o_number_value, want.value);
                    if (o_number_width !== want.width)
                        flag_mismatch("number_width", 64'(o_number_width), 64'(want.width));
                    if (o_payload_length !== want.len)
                        flag_mismatch("payload_length", 64'(o_payload_length), 64'(want.len));
                    if (o_payload_byte !== want.pbyte)
                        flag_mismatch("payload_byte", 64'(o_payload_byte), 64'(want.pbyte));
                    if (o_item_done !== want.done)
                        flag_mismatch("item_done", 64'(o_item_done), 64'(want.done));
                    if (o_last_of_buffer !== want.last)
                        flag_mismatch("last_of_buffer", 64'(o_last_of_buffer), 64'(want.last));
                end
                token_count++;
            end
        end
    end

    // Moves the built buffer into the request queue, end flag on its last byte.
    function automatic void queue_frame();
        t_byte_req req;
        for (int i = 0; i < frame.size(); i++) begin
            req.data = frame[i];
            req.eob  = (i == frame.size() - 1);
            byte_reqs.insert(byte_reqs.size(), req);
        end
        queued_bytes += frame.size();
        frame.delete();
    endfunction

    function automatic logic [7:0] data_byte();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return 8'h00;
        if (pick == 1)
            return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    // Appends one element; returns 1 when the element can never finish in this buffer.
    function automatic logic append_element();
        int          sel;
        int          pick;
        int          sz;
        int          n;
        logic [31:0] len;
        logic [7:0]  b;
        logic        open;
        open = 1'b0;
        sel  = $urandom_range(9);
        if (sel <= 3 || sel == 9) begin
            sz = $urandom_range(3);
            frame.insert(frame.size(), tvsd_pkg::TAG_U8 + 8'(sz));
            b = $urandom_range(1) ? 8'hFF : 8'h00;
            for (int i = 0; i < (1 << sz); i++)
                frame.insert(frame.size(), (sel == 9) ? b : data_byte());
        end else if (sel <= 6) begin
            frame.insert(frame.size(), $urandom_range(1) ? tvsd_pkg::TAG_STR
                                                         : tvsd_pkg::TAG_BARR);
            pick = $urandom_range(99);
            if (pick < 60) begin
                len = 32'($urandom_range(4));
            end else if (pick < 88) begin
                len = 32'($urandom_range(5, 24));
            end else begin
                // huge length: the buffer will end inside the payload
                len  = (pick < 94) ? 32'hFFFF_FFFF : ($urandom | 32'h0000_0100);
                open = 1'b1;
            end
            frame.insert(frame.size(), len[31:24]);
            frame.insert(frame.size(), len[23:16]);
            frame.insert(frame.size(), len[15:8]);
            frame.insert(frame.size(), len[7:0]);
            n = open ? $urandom_range(4) : int'(len);
            for (int i = 0; i < n; i++)
                frame.insert(frame.size(), data_byte());
        end else if (sel == 7) begin
            frame.insert(frame.size(), 8'h00);
        end else begin
            do
                b = 8'($urandom_range(1, 255));
            while (b inside {tvsd_pkg::TAG_U8, tvsd_pkg::TAG_U16, tvsd_pkg::TAG_U32,
                             tvsd_pkg::TAG_U64, tvsd_pkg::TAG_BARR, tvsd_pkg::TAG_STR});
            frame.insert(frame.size(), b);
        end
        return open;
    endfunction

    // Mostly well-formed buffers; some cut short, some pure noise.
    task automatic build_random_frame();
        int mode;
        int n_el;
        int cut;
        mode = $urandom_range(99);
        if (mode < 10) begin
            n_el = $urandom_range(1, 8);
            for (int i = 0; i < n_el; i++)
                frame.insert(frame.size(), 8'($urandom_range(255)));
        end else begin
            n_el = $urandom_range(1, 4);
            for (int i = 0; i < n_el; i++)
                if (append_element())
                    break;
            if (mode < 35 && frame.size() > 1) begin
                cut   = $urandom_range(1, frame.size() - 1);
                frame = frame[0:cut-1];
            end
        end
        queue_frame();
    endtask

    task automatic wait_drained();
        wait (byte_reqs.size() == 0 && !i_valid && expected_tokens.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : run_timeout
        wait (cycles >= CYCLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        int send_pct[4];
        int recv_pct[4];
        send_pct = '{0, 59, 0, 20};
        recv_pct = '{0, 0, 59, 20};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed buffers, no idling
        frame = {8'h00, 8'h84, 8'hFF};              // skips, then clean end on unknown tag
        queue_frame();
        frame = {tvsd_pkg::TAG_U8};                 // ends right after a tag
        queue_frame();
        frame = {tvsd_pkg::TAG_U8, 8'hFF};          // final byte completes a number
        queue_frame();
        frame = {tvsd_pkg::TAG_U16, 8'h12};         // ends inside a number
        queue_frame();
        frame = {tvsd_pkg::TAG_STR, 8'h00, 8'h00, 8'h00, 8'h00};   // empty string closes it
        queue_frame();
        frame = {tvsd_pkg::TAG_BARR, 8'h00, 8'h00, 8'h00, 8'h01};  // length 1, buffer ends: truncation, no header
        queue_frame();
        frame = {tvsd_pkg::TAG_STR, 8'h00, 8'h00, 8'h00, 8'h01, 8'h5A};  // last payload byte
        queue_frame();
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = send_pct[p];
            recv_stall_pct = recv_pct[p];
            queued_bytes   = 0;
            while (queued_bytes < RAND_BYTES)
                build_random_frame();
            wait_drained();
        end

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
